[hw/rtl/hcd_pkg.sv]
// hcd_pkg: shared types, constants and helpers for the chunked body decoder
// no dependencies; imported by the interfaces and every decoder module
`default_nettype none

package hcd_pkg;

  localparam int unsigned SizeLineCharsDefault = 15;
  localparam int unsigned CapW = 21;
  localparam int unsigned CountW = 20;
  localparam int unsigned SizeW = 32;

  localparam logic [CapW-1:0] CapacityReset = CapW'(65536);
  localparam logic [CapW-1:0] MaxEmitCap = CapW'(1 << CountW);

  localparam logic [7:0] CrByte = 8'h0d;
  localparam logic [7:0] LfByte = 8'h0a;

  // why decoding ended
  typedef enum logic [1:0] {
    REASON_ZERO_SIZE = 2'd0,
    REASON_CAPACITY  = 2'd1,
    REASON_INPUT_END = 2'd2
  } reason_e;

  // decoder phases, one-hot
  typedef enum logic [4:0] {
    PH_SKIP_SIZE = 5'b00001,
    PH_SIZE_LINE = 5'b00010,
    PH_SKIP_DATA = 5'b00100,
    PH_DATA      = 5'b01000,
    PH_DONE      = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_end;
  } hcd_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              stream_done;
    logic [CountW-1:0] total_length;
    logic [1:0]        end_reason;
  } hcd_result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t h;
    h.is_hex = 1'b1;
    h.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nibble = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.nibble = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/hcd_if.sv]
// hcd channel interfaces: body input, decoded result output, capacity write
// depends on hcd_pkg for widths
`default_nettype none

interface hcd_body_if import hcd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       body_end;

  modport source (output valid, output body_byte, output body_end, input ready);
  modport sink (input valid, input body_byte, input body_end, output ready);
endinterface

interface hcd_result_if import hcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [7:0]        out_byte;
  logic              byte_valid;
  logic              stream_done;
  logic [CountW-1:0] total_length;
  logic [1:0]        end_reason;

  modport source (output valid, output out_byte, output byte_valid, output stream_done,
                  output total_length, output end_reason, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input stream_done,
                input total_length, input end_reason, output ready);
endinterface

interface hcd_cfg_if import hcd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CapW-1:0] output_capacity;

  modport source (output valid, output output_capacity, input ready);
  modport sink (input valid, input output_capacity, output ready);
endinterface

`default_nettype wire

[hw/rtl/hcd_in_stage.sv]
// hcd_in_stage: input register holding one accepted body byte
// depends on hcd_pkg and hcd_body_if
`default_nettype none

module hcd_in_stage import hcd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hcd_body_if.sink   body_i,
  input  wire logic  advance_i,
  output logic       valid_o,
  output hcd_item_t  item_o
);

  logic      valid_q;
  hcd_item_t item_q;
  logic      take;

  assign body_i.ready = !valid_q || advance_i;
  assign take = body_i.valid && body_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.body_byte <= body_i.body_byte;
      item_q.body_end  <= body_i.body_end;
    end
  end

  assign valid_o = valid_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

[hw/rtl/hcd_decode.sv]
// hcd_decode: framing state and single-pass next-state / result logic
// depends on hcd_pkg
`default_nettype none

module hcd_decode import hcd_pkg::*; #(
  parameter int unsigned SIZE_LINE_CHARS = SizeLineCharsDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire hcd_item_t       item_i,
  input  wire logic            advance_i,
  input  wire logic [CapW-1:0] capacity_i,
  output logic                 res_valid_o,
  output hcd_result_t          res_o
);

  localparam int unsigned CntW = $clog2(SIZE_LINE_CHARS + 1);
  localparam logic [CntW-1:0] LineLast = CntW'(SIZE_LINE_CHARS);

  phase_e            phase_q, phase_d;
  logic [SizeW-1:0]  acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              stop_q, stop_d;
  logic [SizeW-1:0]  rem_q, rem_d;
  logic [CountW-1:0] emit_q, emit_d;
  reason_e           reason_q, reason_d;

  logic [CapW-1:0]  cap_eff;
  logic             at_cap;
  logic             brk;
  logic             emitted;
  logic             line_work;
  logic             line_close;
  logic [SizeW-1:0] line_val;
  logic [SizeW-1:0] acc_new;
  logic [CntW-1:0]  cnt_inc;
  hex_digit_t       hex;

  assign cap_eff = (capacity_i > MaxEmitCap) ? MaxEmitCap : capacity_i;
  assign at_cap = ({1'b0, emit_q} + CapW'(1)) >= cap_eff;
  assign brk = (item_i.body_byte == CrByte) || (item_i.body_byte == LfByte);
  assign hex = hex_value(item_i.body_byte);
  assign cnt_inc = cnt_q + CntW'(1);

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    stop_d     = stop_q;
    rem_d      = rem_q;
    emit_d     = emit_q;
    reason_d   = reason_q;
    emitted    = 1'b0;
    line_work  = 1'b0;
    line_close = 1'b0;
    line_val   = acc_q;
    acc_new    = acc_q;

    if (valid_i && phase_q != PH_DONE) begin
      if (at_cap) begin
        phase_d  = PH_DONE;
        reason_d = REASON_CAPACITY;
      end else begin
        if (phase_q == PH_SKIP_SIZE && !brk) begin
          line_work = 1'b1;
        end
        if (phase_q == PH_SIZE_LINE) begin
          if (brk) begin
            line_close = 1'b1;
          end else begin
            line_work = 1'b1;
          end
        end
        if (line_work) begin
          phase_d = PH_SIZE_LINE;
          if (!stop_q) begin
            if (hex.is_hex) begin
              acc_new = {acc_q[SizeW-5:0], hex.nibble};
            end else begin
              stop_d = 1'b1;
            end
          end
          acc_d = acc_new;
          cnt_d = cnt_inc;
          if (cnt_inc == LineLast) begin
            line_close = 1'b1;
            line_val   = acc_new;
          end
        end
        if (line_close) begin
          acc_d  = '0;
          cnt_d  = '0;
          stop_d = 1'b0;
          if (line_val == '0) begin
            phase_d  = PH_DONE;
            reason_d = REASON_ZERO_SIZE;
          end else begin
            rem_d   = line_val;
            phase_d = PH_SKIP_DATA;
          end
        end
        if ((phase_q == PH_SKIP_DATA && !brk) || phase_q == PH_DATA) begin
          emitted = 1'b1;
          emit_d  = emit_q + CountW'(1);
          rem_d   = rem_q - SizeW'(1);
          phase_d = (rem_q == SizeW'(1)) ? PH_SKIP_SIZE : PH_DATA;
          // check capacity again after the byte is counted
          if (({1'b0, emit_q} + CapW'(2)) >= cap_eff) begin
            phase_d  = PH_DONE;
            reason_d = REASON_CAPACITY;
          end
        end
      end
    end

    res_valid_o        = valid_i && (emitted || item_i.body_end);
    res_o.out_byte     = emitted ? item_i.body_byte : 8'd0;
    res_o.byte_valid   = emitted;
    res_o.stream_done  = item_i.body_end;
    res_o.total_length = emit_d;
    res_o.end_reason   = !item_i.body_end ? REASON_ZERO_SIZE :
                         (phase_d == PH_DONE) ? reason_d : REASON_INPUT_END;

    // end of body: start the next run from reset values
    if (valid_i && item_i.body_end) begin
      phase_d  = PH_SKIP_SIZE;
      acc_d    = '0;
      cnt_d    = '0;
      stop_d   = 1'b0;
      rem_d    = '0;
      emit_d   = '0;
      reason_d = REASON_INPUT_END;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SKIP_SIZE;
      acc_q    <= '0;
      cnt_q    <= '0;
      stop_q   <= 1'b0;
      rem_q    <= '0;
      emit_q   <= '0;
      reason_q <= REASON_INPUT_END;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      stop_q   <= stop_d;
      rem_q    <= rem_d;
      emit_q   <= emit_d;
      reason_q <= reason_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_line_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SIZE_LINE) |-> (cnt_q < LineLast))
    else $error("size line count reached its limit without ending the line");

  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP_DATA || phase_q == PH_DATA) |-> (rem_q != '0))
    else $error("data phase with no bytes remaining");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !item_i.body_end) |-> res_o.byte_valid)
    else $error("result without payload byte or end of body");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && valid_i && item_i.body_end) |=>
      (phase_q == PH_SKIP_SIZE && emit_q == '0 && rem_q == '0))
    else $error("state not cleared after end of body");
`endif

endmodule

`default_nettype wire

[hw/rtl/hcd_out_stage.sv]
// hcd_out_stage: result register toward the downstream sink
// depends on hcd_pkg and hcd_result_if
`default_nettype none

module hcd_out_stage import hcd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire logic        res_valid_i,
  input  wire hcd_result_t res_i,
  output logic             space_o,
  hcd_result_if.source     result_o
);

  logic        valid_q;
  hcd_result_t res_q;

  assign space_o = !valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (result_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid        = valid_q;
  assign result_o.out_byte     = res_q.out_byte;
  assign result_o.byte_valid   = res_q.byte_valid;
  assign result_o.stream_done  = res_q.stream_done;
  assign result_o.total_length = res_q.total_length;
  assign result_o.end_reason   = res_q.end_reason;

endmodule

`default_nettype wire

[hw/rtl/http_chunked_decoder_top.sv]
// http_chunked_decoder_top: chunked transfer decoder, body bytes in, payload out
// depends on hcd_pkg, hcd_if, hcd_in_stage, hcd_decode, hcd_out_stage
//
//   channel   dir  payload                                                  transfer when
//   body_i    in   body_byte[7:0], body_end                                 valid && ready
//   result_o  out  out_byte[7:0], byte_valid, stream_done,
//                  total_length[19:0], end_reason[1:0]                      valid && ready
//   cfg_i     in   output_capacity[20:0]                                    valid && ready
//
// one body byte per cycle sustained while result_o is ready; a byte waits in the input
// register, then its result is registered in the output register that drives result_o
// the size line, skip and data framing state updates in a single pass per byte
// reset clears the framing state and sets output_capacity to 65536
// a stalled result_o holds its register; body_i keeps taking bytes while the held
// byte still has room to move, i.e. only a full input plus a full output stalls
`default_nettype none

module http_chunked_decoder_top import hcd_pkg::*; #(
  parameter int unsigned SIZE_LINE_CHARS = SizeLineCharsDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  hcd_cfg_if.sink      cfg_i,
  hcd_body_if.sink     body_i,
  hcd_result_if.source result_o
);

  // capacity register, to be written only while idle; the block itself does not enforce this
  logic [CapW-1:0] cap_q;

  // pipeline handshake between the stages
  logic        item_valid;
  hcd_item_t   item;
  logic        out_space;
  logic        advance;
  logic        res_valid;
  hcd_result_t res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.output_capacity;
    end
  end

  // the held byte moves on when the result register can take its outcome;
  // bytes with no result still move so framing keeps pace
  assign advance = item_valid && out_space;

  hcd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .body_i    (body_i),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  hcd_decode #(
    .SIZE_LINE_CHARS (SIZE_LINE_CHARS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (item_valid),
    .item_i      (item),
    .advance_i   (advance),
    .capacity_i  (cap_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hcd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (out_space),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

[verif/testbench.sv]
// testbench for http_chunked_decoder_top: a directed table, then random chunked bodies
// depends on hcd_pkg, hcd_if and the decoder rtl; decoded results are checked against a predictor
module testbench;
  import hcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // stream has not ended yet, so the reason field reads as zero
  localparam logic [1:0] ReasonNone = 2'b00;
  localparam int unsigned IdlePct = 29;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned QuietCycles = 6;
  localparam int unsigned BytesPerSetting = 30;

  typedef struct {
    logic [7:0]  data;
    logic        is_last;
    bit          typed;
    hcd_result_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hcd_cfg_if    cfg_ch ();
  hcd_body_if   body_ch ();
  hcd_result_if result_ch ();

  http_chunked_decoder_top #(
    .SIZE_LINE_CHARS(SizeLineCharsDefault)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_ch),
    .body_i  (body_ch),
    .result_o(result_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // decoder shadow state, mirrors the framing state of the block
  // ---------------------------------------------------------------------------
  phase_e          dec_phase;
  logic [31:0]     size_acc;
  int unsigned     line_chars;
  bit              hex_halted;
  logic [31:0]     remaining;
  logic [19:0]     emitted;
  reason_e         finish_why;
  logic [CapW-1:0] capacity;

  // decoded results still owed by the block, oldest first
  hcd_result_t pending_decodes[$];

  int unsigned failures = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_sent = 0;
  int unsigned bodies_sent = 0;

  // knobs shared between the stimulus thread and the result sink
  bit          steady_run = 1'b0;
  int unsigned hold_calls = 0;
  int unsigned holds_taken = 0;
  int unsigned hold_left = 0;

  hcd_item_t body_plan[$];

  function automatic void clear_run();
    dec_phase  = PH_SKIP_SIZE;
    size_acc   = '0;
    line_chars = 0;
    hex_halted = 1'b0;
    remaining  = '0;
    emitted    = '0;
    finish_why = REASON_INPUT_END;
  endfunction

  // one more byte would reach the buffer size; sizes above 2^20 are clipped
  function automatic bit at_limit();
    logic [31:0] lim;
    lim = (capacity > MaxEmitCap) ? 32'(MaxEmitCap) : 32'(capacity);
    return ({12'd0, emitted} + 32'd1) >= lim;
  endfunction

  function automatic void stop_decoding(reason_e why);
    dec_phase  = PH_DONE;
    finish_why = why;
  endfunction

  // a zero size ends the body, anything else opens a chunk
  function automatic void close_size_line();
    if (size_acc == '0) begin
      stop_decoding(REASON_ZERO_SIZE);
    end else begin
      remaining = size_acc;
      dec_phase = PH_SKIP_DATA;
    end
    size_acc   = '0;
    line_chars = 0;
    hex_halted = 1'b0;
  endfunction

  // returns 1 when the byte leaves as payload
  function automatic bit unchunk_byte(logic [7:0] b);
    bit         brk;
    logic [7:0] digit;
    brk   = (b == CrByte) || (b == LfByte);
    digit = '0;
    if (dec_phase == PH_DONE) return 1'b0;
    if (at_limit()) begin
      stop_decoding(REASON_CAPACITY);
      return 1'b0;
    end
    if (dec_phase == PH_SKIP_SIZE) begin
      if (brk) return 1'b0;
      dec_phase = PH_SIZE_LINE;
    end
    if (dec_phase == PH_SIZE_LINE) begin
      if (brk) begin
        close_size_line();
        return 1'b0;
      end
      if (!hex_halted) begin
        if (b >= "0" && b <= "9") begin
          digit = b - 8'h30;
        end else if (b >= "a" && b <= "f") begin
          digit = b - 8'h57;
        end else if (b >= "A" && b <= "F") begin
          digit = b - 8'h37;
        end else begin
          hex_halted = 1'b1;
        end
        // size wraps at 32 bits
        if (!hex_halted) size_acc = {size_acc[27:0], digit[3:0]};
      end
      line_chars++;
      if (line_chars >= SizeLineCharsDefault) close_size_line();
      return 1'b0;
    end
    if (dec_phase == PH_SKIP_DATA) begin
      if (brk) return 1'b0;
      dec_phase = PH_DATA;
    end
    emitted   = emitted + 20'd1;
    remaining = remaining - 32'd1;
    if (remaining == '0) dec_phase = PH_SKIP_SIZE;
    if (at_limit()) stop_decoding(REASON_CAPACITY);
    return 1'b1;
  endfunction

  // full step: at most one result, and body_end starts a fresh body
  function automatic bit unchunk_step(input logic [7:0] b, input logic is_last,
                                      output hcd_result_t r);
    bit out_now;
    out_now        = unchunk_byte(b);
    r.out_byte     = out_now ? b : 8'h00;
    r.byte_valid   = out_now;
    r.stream_done  = is_last;
    r.total_length = emitted;
    r.end_reason   = !is_last ? ReasonNone :
                     (dec_phase == PH_DONE) ? finish_why : REASON_INPUT_END;
    if (is_last) clear_run();
    return out_now || is_last;
  endfunction

  // ---------------------------------------------------------------------------
  // directed part, written against the reset capacity of 65536
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [24] = '{
    // line breaks ahead of the first size line are dropped
    '{8'h0d, 1'b0, 1'b0, '0},
    '{8'h0a, 1'b0, 1'b0, '0},
    '{"3",   1'b0, 1'b0, '0},
    '{8'h0d, 1'b0, 1'b0, '0},
    '{8'h0a, 1'b0, 1'b0, '0},
    // three data bytes: both byte extremes and a cr that is payload
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 20'd1, ReasonNone}},
    '{8'hff, 1'b0, 1'b1, '{8'hff, 1'b1, 1'b0, 20'd2, ReasonNone}},
    '{8'h0d, 1'b0, 1'b1, '{8'h0d, 1'b1, 1'b0, 20'd3, ReasonNone}},
    // size "1g9": hex parsing stops at the g
    '{"1",   1'b0, 1'b0, '0},
    '{"g",   1'b0, 1'b0, '0},
    '{"9",   1'b0, 1'b0, '0},
    '{8'h0a, 1'b0, 1'b0, '0},
    '{8'h0d, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b0, 20'd4, ReasonNone}},
    // zero-size chunk, then a byte that is ignored, then the body end
    '{"0",   1'b0, 1'b0, '0},
    '{8'h0d, 1'b0, 1'b0, '0},
    '{"A",   1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 20'd4, REASON_ZERO_SIZE}},
    // body ends in the middle of a size line
    '{"a",   1'b0, 1'b0, '0},
    '{"F",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 20'd0, REASON_INPUT_END}},
    // body end lands on a payload byte
    '{"2",   1'b0, 1'b0, '0},
    '{8'h0a, 1'b0, 1'b0, '0},
    '{8'h55, 1'b1, 1'b1, '{8'h55, 1'b1, 1'b1, 20'd1, REASON_INPUT_END}},
    // one-byte body, still skipping line breaks
    '{8'h7f, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 20'd0, REASON_INPUT_END}}
  };

  // capacity settings visited by the random part, extremes included
  logic [CapW-1:0] phase_caps [8] = '{
    21'd2, 21'd0, 21'd7, 21'd1048576, 21'd1, 21'h1fffff, 21'd40, 21'd65536
  };

  // ---------------------------------------------------------------------------
  // drivers: inputs change on the falling edge, handshakes sampled on the rising
  // ---------------------------------------------------------------------------

  // offers one body byte; the decode is predicted at the moment of transfer
  task automatic send_item(logic [7:0] data, logic is_last, bit typed, hcd_result_t want);
    hcd_result_t predicted;
    bit          has_result;
    while (!steady_run && $urandom_range(0, 99) < IdlePct) begin
      body_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    body_ch.valid     <= 1'b1;
    body_ch.body_byte <= data;
    body_ch.body_end  <= is_last;
    do @(posedge clk_i); while (!body_ch.ready);
    has_result = unchunk_step(data, is_last, predicted);
    // typed rows carry their own value, the shadow state still advances
    if (typed) begin
      pending_decodes.push_back(want);
    end else if (has_result) begin
      pending_decodes.push_back(predicted);
    end
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // the register only moves while the block has drained
  task automatic write_capacity(logic [CapW-1:0] value);
    // stop offering body bytes while the pipeline drains
    body_ch.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    // bytes without a result may still sit in the pipeline
    repeat (QuietCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.output_capacity <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    capacity = value;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // random body builder
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
    if (nib < 4'd10) return 8'h30 + {4'd0, nib};
    return (upper ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
  endfunction

  function automatic void plan_push(logic [7:0] b);
    body_plan.push_back('{body_byte: b, body_end: 1'b0});
  endfunction

  function automatic void plan_crlf();
    plan_push(CrByte);
    plan_push(LfByte);
  endfunction

  function automatic void plan_data(int unsigned count);
    repeat (count) plan_push(8'($urandom_range(0, 255)));
  endfunction

  // closing zero-size chunk with optional extension and trailer
  function automatic void plan_last_chunk();
    repeat ($urandom_range(1, 2)) plan_push("0");
    if ($urandom_range(0, 3) == 0) plan_push(";");
    plan_crlf();
    if ($urandom_range(0, 3) == 0) plan_data($urandom_range(1, 4));
    plan_crlf();
  endfunction

  function automatic void plan_chunk(int unsigned size);
    int unsigned n;
    bit          upper;
    n     = 1;
    upper = 1'($urandom_range(0, 1));
    while (n < 8 && (size >> (4 * n)) != 0) n++;
    if ($urandom_range(0, 3) == 0) plan_push($urandom_range(0, 1) ? CrByte : LfByte);
    repeat ($urandom_range(0, 1)) plan_push("0");
    for (int i = int'(n) - 1; i >= 0; i--) plan_push(hex_char(4'(size >> (4 * i)), upper));
    // chunk extension, ignored after the first non-hex character
    if ($urandom_range(0, 3) == 0) begin
      plan_push(";");
      plan_push("x");
      plan_push("=");
      plan_push(hex_char(4'($urandom_range(0, 15)), upper));
    end
    if ($urandom_range(0, 2) == 0) plan_push(LfByte);
    else plan_crlf();
    plan_data(size);
    plan_crlf();
  endfunction

  // mostly well-formed bodies; some cut short, some noise, some long size lines
  function automatic void build_body();
    int unsigned kind;
    int unsigned keep;
    logic [3:0]  nib;
    body_plan.delete();
    kind = $urandom_range(0, 9);
    if (kind == 8) begin
      plan_data($urandom_range(1, 20));
    end else if (kind == 9) begin
      if ($urandom_range(0, 1)) begin
        // size line closed by its length; a zero digit ends the body there
        nib = 4'($urandom_range(0, 15));
        repeat (SizeLineCharsDefault - 1) plan_push("0");
        plan_push(hex_char(nib, 1'($urandom_range(0, 1))));
        plan_data(nib);
        plan_last_chunk();
      end else begin
        // full-length hex size that wraps, body ends inside the data
        repeat (SizeLineCharsDefault) begin
          plan_push(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end
        plan_data($urandom_range(1, 8));
      end
    end else begin
      repeat ($urandom_range(0, 3)) begin
        plan_chunk(($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6));
      end
      plan_last_chunk();
      if (kind == 7) begin
        keep = $urandom_range(1, body_plan.size());
        while (body_plan.size() > keep) void'(body_plan.pop_back());
      end
    end
    body_plan[body_plan.size() - 1].body_end = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // result sink: random back-pressure plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_calls != holds_taken) begin
        holds_taken = hold_calls;
        hold_left   = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= steady_run || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  task automatic report_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      failures++;
    end
  endtask

  // every result transfer is matched against the oldest owed decode
  always @(posedge clk_i) begin : check_result
    hcd_result_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      results_checked++;
      if (pending_decodes.size() == 0) begin
        $display("%0t ns: result with none expected, byte 0x%0h valid %0b done %0b len %0d",
                 $time, result_ch.out_byte, result_ch.byte_valid, result_ch.stream_done,
                 result_ch.total_length);
        failures++;
      end else begin
        want = pending_decodes.pop_front();
        report_field("out_byte", want.out_byte, result_ch.out_byte);
        report_field("byte_valid", want.byte_valid, result_ch.byte_valid);
        report_field("stream_done", want.stream_done, result_ch.stream_done);
        report_field("total_length", want.total_length, result_ch.total_length);
        report_field("end_reason", want.end_reason, result_ch.end_reason);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_start;
    body_ch.valid          = 1'b0;
    body_ch.body_byte      = 8'h00;
    body_ch.body_end       = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.output_capacity = '0;
    capacity               = CapacityReset;
    clear_run();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].data, directed_rows[i].is_last, directed_rows[i].typed,
                directed_rows[i].want);
    end
    bodies_sent += 4;

    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_caps[p]);
      // one setting runs with no gaps on either side
      steady_run = (p == 3);
      // last setting: sink holds off while bodies keep coming, so the block stalls
      if (p == 7) hold_calls++;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BytesPerSetting) begin
        build_body();
        foreach (body_plan[i]) begin
          send_item(body_plan[i].body_byte, body_plan[i].body_end, 1'b0, '0);
        end
        bodies_sent++;
      end
      steady_run = 1'b0;
    end
    body_ch.valid <= 1'b0;

    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d body bytes in %0d bodies, %0d results checked", bytes_sent,
             bodies_sent, results_checked);
    $display("capacity settings 0, 1, 2, 7, 40, 65536, 2^20 and 2^21-1 with all stop reasons");
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // generous ceiling, far above the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d results still owed", pending_decodes.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/hcd_pkg.sv
hw/rtl/hcd_if.sv
hw/rtl/hcd_in_stage.sv
hw/rtl/hcd_decode.sv
hw/rtl/hcd_out_stage.sv
hw/rtl/http_chunked_decoder_top.sv
verif/testbench.sv
